[rtl/assert_macros.svh]
// assertion macros shared by the allocator rtl
// no dependencies; included by files that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define FHA_ASSERT(lbl, ck, rs, prop) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) \
    else $error("assertion failed");
`define FHA_ASSERT_ALWAYS(lbl, ck, prop) \
  lbl: assert property (@(posedge ck) prop) else $error("assertion failed");
`else
`define FHA_ASSERT(lbl, ck, rs, prop)
`define FHA_ASSERT_ALWAYS(lbl, ck, prop)
`endif
`endif

[rtl/fha_pkg.sv]
// types and constants of the first-fit heap allocator
// no dependencies
package fha_pkg;

  localparam int ADDR_W = 12;
  localparam int SIZE_W = 13;
  localparam logic [SIZE_W-1:0] HEAP_BYTES = 13'd4096;
  localparam logic [SIZE_W-1:0] USED_HDR_BYTES = 13'd8;
  localparam logic [SIZE_W-1:0] FREE_HDR_BYTES = 13'd16;
  localparam logic [ADDR_W-1:0] HEAD_SLOT = 12'd8;

  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] next;
    logic              nvalid;
  } hdr_t;

  localparam hdr_t INIT_HDR = '{size: HEAP_BYTES - {1'b0, HEAD_SLOT}, next: '0, nvalid: 1'b0};

  typedef struct packed {
    logic              re;
    logic [ADDR_W-1:0] raddr;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    hdr_t              wdata;
  } mem_req_t;

  typedef struct packed {
    logic              ok;
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] block_size;
  } res_t;

  typedef enum logic [18:0] {
    ST_CLEAR  = 19'd1 << 0,
    ST_IDLE   = 19'd1 << 1,
    ST_A_WALK = 19'd1 << 2,
    ST_A_CHK  = 19'd1 << 3,
    ST_A_SPLIT= 19'd1 << 4,
    ST_A_PRD  = 19'd1 << 5,
    ST_A_PWR  = 19'd1 << 6,
    ST_A_CRD  = 19'd1 << 7,
    ST_A_CWR  = 19'd1 << 8,
    ST_F_WALK = 19'd1 << 9,
    ST_F_STEP = 19'd1 << 10,
    ST_F_ZDAT = 19'd1 << 11,
    ST_F_CDAT = 19'd1 << 12,
    ST_F_LINK = 19'd1 << 13,
    ST_F_PWR  = 19'd1 << 14,
    ST_F_ZWR  = 19'd1 << 15,
    ST_DONE   = 19'd1 << 16,
    ST_SPARE0 = 19'd1 << 17,
    ST_SPARE1 = 19'd1 << 18
  } state_t;

  // merged size, saturating at the heap size
  function automatic logic [SIZE_W-1:0] sat_add(logic [SIZE_W-1:0] a, logic [SIZE_W-1:0] b);
    logic [SIZE_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s > {1'b0, HEAP_BYTES}) return HEAP_BYTES;
    return s[SIZE_W-1:0];
  endfunction

endpackage

[rtl/first_fit_heap_allocator.sv]
// channel   | dir | tdata                         | tuser
// s_axis    | in  | req_size[11:0], block_addr    | mode (0 alloc, 1 free)
// m_axis    | out | addr[11:0], block_size[24:12] | ok
// after reset every header slot is cleared; no item is taken meanwhile
// one item at a time, from accept to result; an allocate walks the free list until a block
// fits or the list ends, a free walks past every free block below the freed address; all
// header reads go through the single header store read port
// a finished result waits in the output register; a stalled output holds the sequencer
// depends on fha_pkg, fha_ctrl and fha_mem
module first_fit_heap_allocator import fha_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // req_size[11:0], block_addr[23:12]
  input  logic        s_tuser,   // mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // addr[11:0], block_size[24:12], zero[31:25]
  output logic        m_tuser    // ok
);

  mem_req_t mreq;
  hdr_t     rdata;
  res_t     res;
  res_t     out_r;
  logic     res_valid;
  logic     res_take;

  fha_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .mode       (s_tuser),
    .req_size   (s_tdata[11:0]),
    .block_addr (s_tdata[23:12]),
    .res_valid  (res_valid),
    .res_take   (res_take),
    .res        (res),
    .mreq       (mreq),
    .rdata      (rdata)
  );

  fha_mem u_mem (
    .clk   (clk),
    .req   (mreq),
    .rdata (rdata)
  );

  assign res_take = res_valid && (!m_tvalid || m_tready);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_take) begin
      m_tvalid <= 1'b1;
      out_r    <= res;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tuser = out_r.ok;
  assign m_tdata = {7'b0, out_r.block_size, out_r.addr};

endmodule

[rtl/fha_mem.sv]
// header store: one header per byte offset, registered read
// depends on fha_pkg
module fha_mem import fha_pkg::*; (
  input  logic     clk,
  input  mem_req_t req,
  output hdr_t     rdata
);

  hdr_t mem [0:(1 << ADDR_W)-1];

  // write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

[rtl/fha_ctrl.sv]
// sequencer: list walk, split, insert and coalesce through the header store
// depends on fha_pkg and assert_macros.svh
`include "assert_macros.svh"
module fha_ctrl import fha_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              mode,
  input  logic [ADDR_W-1:0] req_size,
  input  logic [ADDR_W-1:0] block_addr,
  output logic              res_valid,
  input  logic              res_take,
  output res_t              res,
  output mem_req_t          mreq,
  input  hdr_t              rdata
);

  state_t            state;
  logic [ADDR_W-1:0] clr_cnt;
  logic [ADDR_W-1:0] head;
  logic              head_v;
  logic              mode_r;
  logic [SIZE_W-1:0] need;
  logic [ADDR_W-1:0] zone;
  logic [ADDR_W-1:0] cur;
  logic              cvalid;
  logic [ADDR_W-1:0] prev;
  logic              has_prev;
  logic [SIZE_W-1:0] steps;
  logic [SIZE_W-1:0] gsize;
  logic [SIZE_W-1:0] zsize;
  logic [ADDR_W-1:0] lnk_next;
  logic              lnk_valid;
  hdr_t              p_hdr;
  logic              walk_go;
  logic              fwalk_go;
  logic [SIZE_W-1:0] rem;
  logic [SIZE_W:0]   prev_end;
  logic [SIZE_W-1:0] zone_end;
  logic [SIZE_W-1:0] need_in;

  assign walk_go  = cvalid && (steps != HEAP_BYTES);
  assign fwalk_go = walk_go && (cur < zone);
  assign rem      = rdata.size - need;
  assign prev_end = {2'b0, prev} + {1'b0, rdata.size};
  assign zone_end = {1'b0, zone} + zsize;
  assign need_in  = (({1'b0, req_size} < FREE_HDR_BYTES) ? FREE_HDR_BYTES : {1'b0, req_size})
                    + USED_HDR_BYTES;

  assign in_ready  = (state == ST_IDLE);
  assign res_valid = (state == ST_DONE);

  // header store requests for the current step
  always_comb begin
    mreq = '0;
    unique case (state)
      ST_CLEAR: begin
        mreq.we    = 1'b1;
        mreq.waddr = clr_cnt;
        mreq.wdata = (clr_cnt == HEAD_SLOT) ? INIT_HDR : '0;
      end
      ST_A_WALK: begin
        mreq.re    = walk_go;
        mreq.raddr = cur;
      end
      ST_A_SPLIT: begin
        mreq.we    = 1'b1;
        mreq.waddr = lnk_next;
        mreq.wdata = p_hdr;
      end
      ST_A_PRD, ST_F_LINK: begin
        mreq.re    = has_prev;
        mreq.raddr = prev;
      end
      ST_A_PWR: begin
        mreq.we    = 1'b1;
        mreq.waddr = prev;
        mreq.wdata = '{size: rdata.size, next: lnk_next, nvalid: lnk_valid};
      end
      ST_A_CRD: begin
        mreq.re    = 1'b1;
        mreq.raddr = cur;
      end
      ST_A_CWR: begin
        mreq.we    = 1'b1;
        mreq.waddr = cur;
        mreq.wdata = '{size: gsize, next: rdata.next, nvalid: rdata.nvalid};
      end
      ST_F_WALK: begin
        mreq.re    = 1'b1;
        mreq.raddr = fwalk_go ? cur : zone;
      end
      ST_F_ZDAT: begin
        mreq.re    = cvalid;
        mreq.raddr = cur;
      end
      ST_F_PWR: begin
        mreq.we    = 1'b1;
        mreq.waddr = prev;
        if (prev_end == {2'b0, zone}) begin
          mreq.wdata = '{size: sat_add(rdata.size, p_hdr.size), next: p_hdr.next,
                         nvalid: p_hdr.nvalid};
        end else begin
          mreq.wdata = '{size: rdata.size, next: zone, nvalid: 1'b1};
        end
      end
      ST_F_ZWR: begin
        mreq.we    = 1'b1;
        mreq.waddr = zone;
        mreq.wdata = p_hdr;
      end
      default: begin
        mreq = '0;
      end
    endcase
  end

  // sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
      head    <= HEAD_SLOT;
      head_v  <= 1'b1;
      steps   <= '0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == '1) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_valid) begin
            mode_r   <= mode;
            need     <= need_in;
            zone     <= block_addr;
            cur      <= head;
            cvalid   <= head_v;
            has_prev <= 1'b0;
            steps    <= '0;
            state    <= mode ? ST_F_WALK : ST_A_WALK;
          end
        end
        ST_A_WALK: begin
          if (walk_go) begin
            state <= ST_A_CHK;
          end else begin
            res   <= '0;
            state <= ST_DONE;
          end
        end
        ST_A_CHK: begin
          if (rdata.size < need) begin
            prev     <= cur;
            has_prev <= 1'b1;
            cvalid   <= rdata.nvalid;
            cur      <= rdata.next;
            steps    <= steps + 1'b1;
            state    <= ST_A_WALK;
          end else if (rem < FREE_HDR_BYTES) begin
            // whole block handed over
            gsize     <= rdata.size;
            lnk_next  <= rdata.next;
            lnk_valid <= rdata.nvalid;
            if (has_prev) begin
              state <= ST_A_PRD;
            end else begin
              head   <= rdata.next;
              head_v <= rdata.nvalid;
              state  <= ST_A_CRD;
            end
          end else begin
            // split, remainder becomes a new free block
            gsize     <= need;
            lnk_next  <= cur + need[ADDR_W-1:0];
            lnk_valid <= 1'b1;
            p_hdr     <= '{size: rem, next: rdata.next, nvalid: rdata.nvalid};
            state     <= ST_A_SPLIT;
          end
        end
        ST_A_SPLIT: begin
          if (has_prev) begin
            state <= ST_A_PRD;
          end else begin
            head   <= lnk_next;
            head_v <= 1'b1;
            state  <= ST_A_CRD;
          end
        end
        ST_A_PRD: state <= ST_A_PWR;
        ST_A_PWR: state <= ST_A_CRD;
        ST_A_CRD: state <= ST_A_CWR;
        ST_A_CWR: begin
          res   <= '{ok: 1'b1, addr: cur, block_size: gsize};
          state <= ST_DONE;
        end
        ST_F_WALK: begin
          if (fwalk_go) begin
            state <= ST_F_STEP;
          end else begin
            cvalid <= walk_go;
            state  <= ST_F_ZDAT;
          end
        end
        ST_F_STEP: begin
          prev     <= cur;
          has_prev <= 1'b1;
          cvalid   <= rdata.nvalid;
          cur      <= rdata.next;
          steps    <= steps + 1'b1;
          state    <= ST_F_WALK;
        end
        ST_F_ZDAT: begin
          zsize <= rdata.size;
          if (cvalid) begin
            state <= ST_F_CDAT;
          end else begin
            p_hdr <= '{size: rdata.size, next: '0, nvalid: 1'b0};
            state <= ST_F_LINK;
          end
        end
        ST_F_CDAT: begin
          // merge with the following free block when adjacent
          if (zone_end == {1'b0, cur}) begin
            p_hdr <= '{size: sat_add(zsize, rdata.size), next: rdata.next,
                       nvalid: rdata.nvalid};
          end else begin
            p_hdr <= '{size: zsize, next: cur, nvalid: 1'b1};
          end
          state <= ST_F_LINK;
        end
        ST_F_LINK: begin
          if (has_prev) begin
            state <= ST_F_PWR;
          end else begin
            head   <= zone;
            head_v <= 1'b1;
            state  <= ST_F_ZWR;
          end
        end
        ST_F_PWR: state <= ST_F_ZWR;
        ST_F_ZWR: begin
          res   <= '{ok: 1'b1, addr: zone, block_size: '0};
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (res_take) state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `FHA_ASSERT(a_no_rw_same, clk, rst, !(mreq.re && mreq.we))
  `FHA_ASSERT(a_busy_after_accept, clk, rst, (in_valid && in_ready) |=> !in_ready)
  `FHA_ASSERT(a_free_size_zero, clk, rst, (res_valid && mode_r) |-> (res.block_size == '0))
  `FHA_ASSERT(a_steps_bound, clk, rst, (state != ST_CLEAR) |-> (steps <= HEAP_BYTES))
  `FHA_ASSERT_ALWAYS(a_clear_after_reset, clk, rst |=> (state == ST_CLEAR))

endmodule
